@@ rtl/mh2_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mh2_pkg: shared types and constants for the MurmurHash2 stream block
// Multiplier constant, shift amounts, stream packing and the work-queue entry.
// ----------------------------------------------------------------------------
package mh2_pkg;

  localparam logic [31:0] MIX_MUL       = 32'h5bd1e995;
  localparam int          WORD_SHIFT    = 24;
  localparam int          FINAL_SHIFT_A = 13;
  localparam int          FINAL_SHIFT_B = 15;

  // Input tdata: data_word [31:0], valid_bytes [34:32], message_length [66:35]
  localparam int S_TDATA_W = 72;
  localparam int M_TDATA_W = 32;

  localparam int QUEUE_DEPTH_DEF = 4;

  // What the back end has to do with one word
  typedef enum logic [1:0] {
    KIND_FULL = 2'd0,   // full word mix
    KIND_TAIL = 2'd1,   // 1 to 3 trailing bytes
    KIND_NONE = 2'd2    // empty last word
  } kind_t;

  typedef struct packed {
    logic [31:0] word;   // tail bytes already masked
    logic [31:0] init;   // seed ^ length, used when first is set
    kind_t       kind;
    logic        first;
    logic        last;
  } entry_t;

  // Low 32 bits of x * MIX_MUL
  function automatic logic [31:0] mul_m(input logic [31:0] x);
    logic [63:0] p;
    p = {32'd0, x} * {32'd0, MIX_MUL};
    return p[31:0];
  endfunction

endpackage

@@ rtl/mh2_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mh2_front: request intake and classification
// Tracks message boundaries, samples the seed on the first word, masks tail
// bytes and pushes one work entry per request into the queue.
// ----------------------------------------------------------------------------
module mh2_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [31:0]                     cfg_wdata,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [mh2_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  input  logic                            s_axis_tlast,
  output logic                            q_push,
  output mh2_pkg::entry_t                 q_data,
  input  logic                            q_full
);
  import mh2_pkg::*;

  logic [31:0] hash_seed;
  logic        in_message;
  logic [31:0] data_word;
  logic [2:0]  valid_bytes;
  logic [31:0] message_length;

  assign data_word      = s_axis_tdata[31:0];
  assign valid_bytes    = s_axis_tdata[34:32];
  assign message_length = s_axis_tdata[66:35];

  assign s_axis_tready = !q_full;
  assign q_push        = s_axis_tvalid && !q_full;

  // Seed register
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_seed <= '0;
    end else if (cfg_we) begin
      hash_seed <= cfg_wdata;
    end
  end

  // Message boundary tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      in_message <= 1'b0;
    end else if (q_push) begin
      in_message <= !s_axis_tlast;
    end
  end

  // Classification; valid byte counts of 4 and above mean a full word
  always_comb begin
    q_data.init  = hash_seed ^ message_length;
    q_data.first = !in_message;
    q_data.last  = s_axis_tlast;
    q_data.word  = data_word;
    q_data.kind  = KIND_FULL;
    if (s_axis_tlast) begin
      unique case (valid_bytes)
        3'd0: begin
          q_data.kind = KIND_NONE;
        end
        3'd1: begin
          q_data.kind = KIND_TAIL;
          q_data.word = {24'd0, data_word[7:0]};
        end
        3'd2: begin
          q_data.kind = KIND_TAIL;
          q_data.word = {16'd0, data_word[15:0]};
        end
        3'd3: begin
          q_data.kind = KIND_TAIL;
          q_data.word = {8'd0, data_word[23:0]};
        end
        default: begin
          q_data.kind = KIND_FULL;
        end
      endcase
    end
  end

endmodule

@@ rtl/mh2_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mh2_queue: work queue between front and back
// Small FIFO of work entries; DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module mh2_queue #(
  parameter int DEPTH = mh2_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mh2_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output mh2_pkg::entry_t pop_data,
  output logic            empty
);
  import mh2_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/mh2_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mh2_back: hash sequencer
// Runs word mix, tail and final avalanche steps over one shared constant
// multiplier, and holds the result in the output register.
// ----------------------------------------------------------------------------
module mh2_back (
  input  logic                          clk,
  input  logic                          rst,
  input  mh2_pkg::entry_t               q_data,
  input  logic                          q_empty,
  output logic                          q_pop,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [mh2_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import mh2_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_KW   = 6'b000010,   // k = w * M
    S_KK   = 6'b000100,   // k = (k ^ k >> 24) * M
    S_HM   = 6'b001000,   // h = h * M ^ k
    S_AV   = 6'b010000,   // h = (h ^ h >> 13) * M
    S_FIN  = 6'b100000    // h ^ h >> 15 to output
  } state_t;

  state_t      state;
  logic [31:0] acc;
  logic [31:0] k;
  logic [31:0] word_r;
  logic        last_r;
  logic [31:0] h_base;
  logic [31:0] mul_in;
  logic [31:0] prod;
  logic        out_free;

  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign h_base   = q_data.first ? q_data.init : acc;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // Shared multiplier operand
  always_comb begin
    unique case (state)
      S_KW:    mul_in = word_r;
      S_KK:    mul_in = k ^ (k >> WORD_SHIFT);
      S_AV:    mul_in = acc ^ (acc >> FINAL_SHIFT_A);
      default: mul_in = acc;
    endcase
  end

  assign prod = mul_m(mul_in);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            unique case (q_data.kind)
              KIND_TAIL: state <= S_HM;
              KIND_NONE: state <= S_AV;
              default:   state <= S_KW;
            endcase
          end
        end
        S_KW:  state <= S_KK;
        S_KK:  state <= S_HM;
        S_HM:  state <= last_r ? S_AV : S_IDLE;
        S_AV:  state <= S_FIN;
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (!q_empty) begin
          word_r <= q_data.word;
          last_r <= q_data.last;
          k      <= '0;
          if (q_data.kind == KIND_TAIL) begin
            acc <= h_base ^ q_data.word;
          end else begin
            acc <= h_base;
          end
        end
      end
      S_KW:    k   <= prod;
      S_KK:    k   <= prod;
      S_HM:    acc <= prod ^ k;
      S_AV:    acc <= prod;
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      m_axis_tdata <= acc ^ (acc >> FINAL_SHIFT_B);
    end
  end

endmodule

@@ rtl/murmur2_hash_stream.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// murmur2_hash_stream: streaming 32-bit MurmurHash2
// Front end classifies words, a work queue decouples it from the hash engine.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one little-endian message word per request; tlast marks
//   the final word, whose valid byte count (0..7, 4 and up is full) selects
//   full mix, tail or nothing. The length field is taken on the first word
//   and XORed with the seed (cfg_we / cfg_wdata) to start the hash. An empty
//   message is one tlast request with zero valid bytes.
//   m_axis gives one 32-bit hash per message after its last word.
//   Sequencing: the hash engine handles a full word as pop, two key
//   multiplies and hash multiply, a tail as pop and hash multiply and an
//   empty word as pop alone; after the last word come the avalanche
//   multiply and the final shift into the output register. One shared
//   32x32 multiplier sets this order; a new word is popped only when the
//   engine is idle again, so words queued ahead of a last word delay it.
//   The front accepts requests while the queue has room, so words keep
//   flowing during mixing and while a result waits on m_axis_tready.
//   Reset clears the seed, the queue and any partial message. A stalled
//   receiver holds the result; the engine then halts and the queue fills.
// ----------------------------------------------------------------------------
module murmur2_hash_stream #(
  parameter int QUEUE_DEPTH = mh2_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [31:0]                   cfg_wdata,    // hash_seed
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // data_word [31:0], valid_bytes [34:32], message_length [66:35], zero pad
  input  logic [mh2_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input  logic                          s_axis_tlast, // last_word
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [mh2_pkg::M_TDATA_W-1:0] m_axis_tdata  // hash_result [31:0]
);
  import mh2_pkg::*;

  entry_t push_data;
  entry_t pop_data;
  logic   push;
  logic   pop;
  logic   q_full;
  logic   q_empty;

  mh2_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .q_push        (push),
    .q_data        (push_data),
    .q_full        (q_full)
  );

  mh2_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  mh2_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_data        (pop_data),
    .q_empty       (q_empty),
    .q_pop         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

@@ rtl/mh2_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mh2_checker: port-level checks for the MurmurHash2 stream block
// Counts messages in flight and checks results against them.
// ----------------------------------------------------------------------------
module mh2_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          s_axis_tlast,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [mh2_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import mh2_pkg::*;

  logic       last_acc;
  logic       out_acc;
  logic [7:0] pending;

  assign last_acc = s_axis_tvalid && s_axis_tready && s_axis_tlast;
  assign out_acc  = m_axis_tvalid && m_axis_tready;

  // Messages whose last word is in but whose hash is not yet taken
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {7'd0, last_acc} - {7'd0, out_acc};
    end
  end

  // Result register empty right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // No result without a finished message in flight
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> pending != 8'd0)
    else $error("result without a pending message");

  // Result not yet valid in the cycle after an idle last word
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    (last_acc && pending == 8'd0 && !m_axis_tvalid) |=> !m_axis_tvalid)
    else $error("result too early");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind murmur2_hash_stream mh2_checker u_mh2_checker (.*);

@@ verif/murmur2_hash_stream_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// murmur2_hash_stream_test: self-checking bench for the MurmurHash2 stream
// Feeds hand-picked and random messages through s_axis under bursty traffic,
// predicts each 32-bit hash in the bench and checks every m_axis result in
// order while the receiver stalls on shifting patterns. Seed changes happen
// only between drained phases.
// ----------------------------------------------------------------------------
module murmur2_hash_stream_test;
  import mh2_pkg::*;

  localparam logic [31:0] HASH_MUL   = 32'h5bd1e995;
  localparam int          TDATA_PAD  = S_TDATA_W - 67;
  localparam int          DRAIN_WAIT = 12;      // idle cycles before a seed write or the end of a pause
  localparam int          END_WAIT   = 20;
  localparam int          PHASE_WORDS = 400;

  // Receiver stall patterns
  typedef enum logic [1:0] {
    RX_OPEN   = 2'd0,
    RX_RANDOM = 2'd1,
    RX_SPARSE = 2'd2,
    RX_PULSE  = 2'd3
  } rx_mode_t;

  // One queued request: a message word, a seed write, or a drain pause
  typedef struct {
    bit          is_cfg;
    bit          hold;
    logic [31:0] word;     // seed value for a seed write
    logic [2:0]  nbytes;
    bit          last;
    logic [31:0] len;
  } hash_req_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [31:0]          cfg_wdata = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // data_word [31:0], valid_bytes [34:32], message_length [66:35], zero pad
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 s_axis_tlast = 1'b0;  // last_word
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;         // hash_result [31:0]

  hash_req_t   pending_reqs[$];
  logic [31:0] hash_expect[$];

  // Shadow of the block's state
  logic [31:0] seed_shadow = '0;
  logic [31:0] run_hash = '0;
  bit          in_msg = 1'b0;

  bit       req_fired = 1'b0;
  int       burst_left = 0;
  int       gap_left = 0;
  int       settle_cnt = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;

  int err_count = 0;
  int req_count = 0;
  int hash_count = 0;
  int seed_writes = 0;
  int queued_words = 0;

  murmur2_hash_stream dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Full-word mix into the running hash
  function automatic logic [31:0] fold_word(input logic [31:0] h, input logic [31:0] w);
    logic [31:0] k;
    k = w * HASH_MUL;
    k = k ^ (k >> 24);
    k = k * HASH_MUL;
    return (h * HASH_MUL) ^ k;
  endfunction

  // Final avalanche
  function automatic logic [31:0] avalanche(input logic [31:0] h);
    logic [31:0] x;
    x = h ^ (h >> 13);
    x = x * HASH_MUL;
    return x ^ (x >> 15);
  endfunction

  task automatic add_word(input logic [31:0] w, input logic [2:0] nb, input bit last,
                          input logic [31:0] len);
    hash_req_t r;
    r = '{is_cfg: 1'b0, hold: 1'b0, word: w, nbytes: nb, last: last, len: len};
    pending_reqs.push_back(r);
    queued_words++;
  endtask

  task automatic add_cfg(input logic [31:0] seed);
    hash_req_t r;
    r = '{is_cfg: 1'b1, hold: 1'b0, word: seed, nbytes: 3'd0, last: 1'b0, len: '0};
    pending_reqs.push_back(r);
  endtask

  task automatic add_hold();
    hash_req_t r;
    r = '{is_cfg: 1'b0, hold: 1'b1, word: '0, nbytes: 3'd0, last: 1'b0, len: '0};
    pending_reqs.push_back(r);
  endtask

  // Mostly short messages with a consistent length, a few long or mislabeled
  task automatic add_random_message();
    int          nwords;
    int          nb;
    logic [31:0] len;
    nwords = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
    nb = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
    if ($urandom_range(0, 5) == 0)
      len = $urandom();
    else
      len = 4 * (nwords - 1) + ((nb > 4) ? 4 : nb);
    for (int i = 0; i < nwords - 1; i++) begin
      add_word($urandom(), 3'($urandom_range(0, 7)), 1'b0, (i == 0) ? len : $urandom());
    end
    add_word($urandom(), 3'(nb), 1'b1, (nwords == 1) ? len : $urandom());
  endtask

  // Result check and predictor, sampled at the rising edge
  always @(posedge clk) begin : monitor
    logic [31:0] w;
    logic [31:0] h;
    logic [31:0] exp_hash;
    logic [2:0]  nb;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (hash_expect.size() == 0) begin
          $error("hash_result: unexpected result %h", m_axis_tdata);
          err_count++;
        end else begin
          exp_hash = hash_expect.pop_front();
          hash_count++;
          if (m_axis_tdata !== exp_hash) begin
            $error("hash_result: expected %h, actual %h", exp_hash, m_axis_tdata);
            err_count++;
          end
        end
      end
      if (cfg_we) begin
        seed_shadow = cfg_wdata;
        seed_writes++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        req_fired = 1'b1;
        req_count++;
        w  = s_axis_tdata[31:0];
        nb = s_axis_tdata[34:32];
        h  = in_msg ? run_hash : (seed_shadow ^ s_axis_tdata[66:35]);
        if (!s_axis_tlast) begin
          run_hash = fold_word(h, w);
          in_msg   = 1'b1;
        end else begin
          if (nb >= 3'd4) begin
            h = fold_word(h, w);
          end else if (nb != 3'd0) begin
            h = h ^ (w & ((32'd1 << (8 * nb)) - 32'd1));
            h = h * HASH_MUL;
          end
          h        = avalanche(h);
          run_hash = h;
          in_msg   = 1'b0;
          hash_expect.push_back(h);
        end
      end
    end
  end

  // Request driver: bursts with gaps, drains before seed writes and pauses
  always @(negedge clk) begin : driver
    hash_req_t head;
    logic      vld_n;
    logic      we_n;
    vld_n = s_axis_tvalid;
    we_n  = 1'b0;
    if (!rst && !(s_axis_tvalid && !req_fired)) begin
      req_fired = 1'b0;
      vld_n     = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
      end else if (pending_reqs.size() != 0) begin
        head = pending_reqs[0];
        if (head.is_cfg || head.hold) begin
          if (hash_expect.size() != 0) begin
            settle_cnt = 0;
          end else if (settle_cnt < DRAIN_WAIT) begin
            settle_cnt++;
          end else begin
            settle_cnt = 0;
            void'(pending_reqs.pop_front());
            if (head.is_cfg) begin
              we_n = 1'b1;
              cfg_wdata <= head.word;
            end
          end
        end else begin
          void'(pending_reqs.pop_front());
          vld_n = 1'b1;
          s_axis_tdata <= {{TDATA_PAD{1'b0}}, head.len, head.nbytes, head.word};
          s_axis_tlast <= head.last;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 7))
              0, 1, 2: gap_left = 0;
              7:       gap_left = $urandom_range(20, 40);
              default: gap_left = $urandom_range(1, 6);
            endcase
          end
        end
      end
    end
    s_axis_tvalid <= vld_n;
    cfg_we        <= we_n;
  end

  // Receiver stall pattern, picked at random and switched after a random run
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 300);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_OPEN:   m_axis_tready <= 1'b1;
      RX_RANDOM: m_axis_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: m_axis_tready <= ($urandom_range(0, 7) == 0);
      default:   m_axis_tready <= (rx_left % 5) < 3;
    endcase
  end

  // Stimulus and end of run
  initial begin : stimulus
    logic [31:0] phase_seeds[5];
    int          phase_start;
    // Hand-picked cases under the reset seed
    add_word(32'h0000_0000, 3'd0, 1'b1, 32'h0000_0000);          // empty message
    add_word(32'hffff_ffff, 3'd0, 1'b1, 32'hffff_ffff);          // empty, max length
    for (int nb = 1; nb <= 7; nb++)                              // tails, full, oversize
      add_word(32'hffff_ffff, 3'(nb), 1'b1, (nb > 4) ? 4 : nb);
    add_word(32'h0000_0000, 3'd7, 1'b0, 32'd5);                  // count ignored mid-message
    add_word(32'h89ab_cdef, 3'd1, 1'b1, $urandom());
    add_word(32'hffff_ffff, 3'd0, 1'b0, 32'd1);                  // length disagrees
    add_word(32'h1234_5678, 3'd4, 1'b0, 32'h0000_0000);
    add_word(32'h0000_0000, 3'd4, 1'b1, 32'h0000_0000);
    add_hold();
    add_cfg(32'hffff_ffff);
    add_word(32'h0000_0000, 3'd0, 1'b1, 32'h0000_0000);
    add_word(32'hffff_ffff, 3'd4, 1'b1, 32'hffff_ffff);
    add_word(32'hffff_ffff, 3'd2, 1'b0, 32'h0000_0000);
    add_word(32'ha5a5_a5a5, 3'd3, 1'b1, 32'd7);

    // Random phases, each under its own seed
    phase_seeds = '{32'h0000_0000, $urandom(), 32'hffff_ffff, $urandom(), $urandom()};
    for (int p = 0; p < 5; p++) begin
      add_cfg(phase_seeds[p]);
      phase_start = queued_words;
      while (queued_words - phase_start < PHASE_WORDS) begin
        add_random_message();
        if ($urandom_range(0, 59) == 0)
          add_hold();
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || s_axis_tvalid || hash_expect.size() != 0)
      @(posedge clk);
    repeat (END_WAIT) @(posedge clk);
    if (hash_expect.size() != 0) begin
      $error("hash_result: %0d expected results never arrived", hash_expect.size());
      err_count++;
    end

    $display("Run covered %0d words, %0d hashes compared, %0d seed writes,",
             req_count, hash_count, seed_writes);
    $display("with empty, tail, full and oversize last words under bursty traffic.");
    if (err_count == 0) begin
      $display("murmur2_hash_stream verification clean");
    end else begin
      $display("murmur2_hash_stream verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("murmur2_hash_stream verification failed");
    $finish;
  end

endmodule
